### sv/cxyz_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cxyz_pkg
// shared constants, beat types and the cie 1931 2-degree matching table
// (unsigned q1.14, 5 nm rows from 380 nm) for the color matching interpolator
// ----------------------------------------------------------------------------
package cxyz_pkg;

  localparam int DEF_TABLE_ENTRIES = 81;
  localparam int ROM_ROWS          = 128;
  localparam int ROM_AW            = $clog2(ROM_ROWS);
  localparam int WL_W              = 16;
  localparam int W_W               = 15;
  localparam int R_W               = 7;
  localparam int NCH               = 3;
  localparam int BASE_Q4           = 6080;
  localparam int STEP_Q4           = 80;
  localparam int SUM_W             = 22;

  typedef logic [NCH-1:0][W_W-1:0] xyz_t;

  typedef struct packed {
    logic              valid;
    logic [ROM_AW-1:0] idx;
    logic [R_W-1:0]    frac;
    logic              covered;
    logic              last;
  } idx_beat_t;

  typedef struct packed {
    logic           valid;
    xyz_t           lo;
    xyz_t           hi;
    logic [R_W-1:0] frac;
    logic           covered;
    logic           last;
  } row_beat_t;

  function automatic xyz_t xyz(input logic [W_W-1:0] x, input logic [W_W-1:0] y,
                               input logic [W_W-1:0] z);
    xyz_t v;
    v[0] = x;
    v[1] = y;
    v[2] = z;
    return v;
  endfunction

  // rows past the tabulated points read as zero
  function automatic xyz_t cmf_row(input logic [ROM_AW-1:0] a);
    xyz_t v;
    case (a)
      7'd0:  v = xyz(15'd23, 15'd0, 15'd106);
      7'd1:  v = xyz(15'd36, 15'd2, 15'd172);
      7'd2:  v = xyz(15'd69, 15'd2, 15'd329);
      7'd3:  v = xyz(15'd125, 15'd3, 15'd593);
      7'd4:  v = xyz(15'd234, 15'd7, 15'd1112);
      7'd5:  v = xyz(15'd380, 15'd10, 15'd1806);
      7'd6:  v = xyz(15'd713, 15'd20, 15'd3398);
      7'd7:  v = xyz(15'd1271, 15'd36, 15'd6083);
      7'd8:  v = xyz(15'd2202, 15'd66, 15'd10578);
      7'd9:  v = xyz(15'd3519, 15'd120, 15'd17025);
      7'd10: v = xyz(15'd4651, 15'd190, 15'd22702);
      7'd11: v = xyz(15'd5382, 15'd275, 15'd26591);
      7'd12: v = xyz(15'd5707, 15'd377, 15'd28624);
      7'd13: v = xyz(15'd5703, 15'd488, 15'd29206);
      7'd14: v = xyz(15'd5508, 15'd623, 15'd29034);
      7'd15: v = xyz(15'd5222, 15'd786, 15'd28575);
      7'd16: v = xyz(15'd4764, 15'd983, 15'd27348);
      7'd17: v = xyz(15'd4114, 15'd1211, 15'd25036);
      7'd18: v = xyz(15'd3201, 15'd1491, 15'd21096);
      7'd19: v = xyz(15'd2328, 15'd1845, 15'd17070);
      7'd20: v = xyz(15'd1566, 15'd2277, 15'd13320);
      7'd21: v = xyz(15'd950, 15'd2774, 15'd10096);
      7'd22: v = xyz(15'd524, 15'd3408, 15'd7622);
      7'd23: v = xyz(15'd241, 15'd4237, 15'd5788);
      7'd24: v = xyz(15'd80, 15'd5292, 15'd4456);
      7'd25: v = xyz(15'd39, 15'd6673, 15'd3478);
      7'd26: v = xyz(15'd152, 15'd8241, 15'd2592);
      7'd27: v = xyz(15'd477, 15'd9965, 15'd1830);
      7'd28: v = xyz(15'd1037, 15'd11633, 15'd1281);
      7'd29: v = xyz(15'd1796, 15'd12996, 15'd939);
      7'd30: v = xyz(15'd2712, 15'd14123, 15'd691);
      7'd31: v = xyz(15'd3698, 15'd14990, 15'd488);
      7'd32: v = xyz(15'd4758, 15'd15630, 15'd333);
      7'd33: v = xyz(15'd5893, 15'd16061, 15'd220);
      7'd34: v = xyz(15'd7101, 15'd16302, 15'd143);
      7'd35: v = xyz(15'd8390, 15'd16384, 15'd93);
      7'd36: v = xyz(15'd9740, 15'd16302, 15'd64);
      7'd37: v = xyz(15'd11115, 15'd16033, 15'd44);
      7'd38: v = xyz(15'd12486, 15'd15598, 15'd34);
      7'd39: v = xyz(15'd13804, 15'd14998, 15'd29);
      7'd40: v = xyz(15'd15013, 15'd14254, 15'd28);
      7'd41: v = xyz(15'd16033, 15'd13374, 15'd23);
      7'd42: v = xyz(15'd16815, 15'd12403, 15'd18);
      7'd43: v = xyz(15'd17313, 15'd11385, 15'd16);
      7'd44: v = xyz(15'd17403, 15'd10338, 15'd13);
      7'd45: v = xyz(15'd17131, 15'd9286, 15'd10);
      7'd46: v = xyz(15'd16427, 15'd8241, 15'd5);
      7'd47: v = xyz(15'd15375, 15'd7229, 15'd3);
      7'd48: v = xyz(15'd13998, 15'd6242, 15'd3);
      7'd49: v = xyz(15'd12311, 15'd5259, 15'd2);
      7'd50: v = xyz(15'd10525, 15'd4342, 15'd0);
      7'd51: v = xyz(15'd8878, 15'd3555, 15'd0);
      7'd52: v = xyz(15'd7338, 15'd2867, 15'd0);
      7'd53: v = xyz(15'd5911, 15'd2264, 15'd0);
      7'd54: v = xyz(15'd4645, 15'd1753, 15'd0);
      7'd55: v = xyz(15'd3583, 15'd1337, 15'd0);
      7'd56: v = xyz(15'd2702, 15'd999, 15'd0);
      7'd57: v = xyz(15'd1986, 15'd731, 15'd0);
      7'd58: v = xyz(15'd1432, 15'd524, 15'd0);
      7'd59: v = xyz(15'd1042, 15'd380, 15'd0);
      7'd60: v = xyz(15'd767, 15'd279, 15'd0);
      7'd61: v = xyz(15'd539, 15'd195, 15'd0);
      7'd62: v = xyz(15'd372, 15'd134, 15'd0);
      7'd63: v = xyz(15'd259, 15'd93, 15'd0);
      7'd64: v = xyz(15'd187, 15'd67, 15'd0);
      7'd65: v = xyz(15'd133, 15'd48, 15'd0);
      7'd66: v = xyz(15'd95, 15'd34, 15'd0);
      7'd67: v = xyz(15'd67, 15'd25, 15'd0);
      7'd68: v = xyz(15'd48, 15'd16, 15'd0);
      7'd69: v = xyz(15'd33, 15'd11, 15'd0);
      7'd70: v = xyz(15'd23, 15'd8, 15'd0);
      7'd71: v = xyz(15'd16, 15'd7, 15'd0);
      7'd72: v = xyz(15'd11, 15'd3, 15'd0);
      7'd73: v = xyz(15'd8, 15'd3, 15'd0);
      7'd74: v = xyz(15'd5, 15'd2, 15'd0);
      7'd75: v = xyz(15'd3, 15'd2, 15'd0);
      7'd76: v = xyz(15'd3, 15'd2, 15'd0);
      7'd77: v = xyz(15'd2, 15'd0, 15'd0);
      7'd78: v = xyz(15'd2, 15'd0, 15'd0);
      7'd79: v = xyz(15'd2, 15'd0, 15'd0);
      default: v = xyz(15'd0, 15'd0, 15'd0);
    endcase
    return v;
  endfunction

endpackage

### sv/cxyz_index.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cxyz_index
// range check and split of the wavelength into table row and 1/16 nm offset
// ----------------------------------------------------------------------------
module cxyz_index import cxyz_pkg::*; #(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            beat_in,
  input  logic [WL_W-1:0] wavelength_nm,
  input  logic            last_in,
  output idx_beat_t       idx_beat
);

  localparam int SPAN   = (TABLE_ENTRIES - 1) * STEP_Q4;
  localparam int D_W    = 14;
  localparam int DH_W   = D_W - 4;
  localparam int RCP5   = 205;
  localparam int PROD_W = DH_W + 8;

  logic [WL_W-1:0]   d;
  logic              in_range;
  logic [DH_W-1:0]   dh;
  logic [PROD_W-1:0] prod;
  logic [ROM_AW-1:0] q;
  logic [D_W-1:0]    rem;
  idx_beat_t         beat_r, beat_nxt;

  always_comb begin
    d        = wavelength_nm - WL_W'(BASE_Q4);
    in_range = (wavelength_nm >= WL_W'(BASE_Q4)) && (32'(d) < SPAN);
    dh       = d[D_W-1:4];
    // floor(dh / 5) for dh below 640
    prod     = PROD_W'(dh) * PROD_W'(RCP5);
    q        = prod[PROD_W-2 -: ROM_AW];
    rem      = d[D_W-1:0] - D_W'(q) * D_W'(STEP_Q4);
    beat_nxt.valid   = beat_in;
    beat_nxt.idx     = in_range ? q : '0;
    beat_nxt.frac    = in_range ? rem[R_W-1:0] : '0;
    beat_nxt.covered = in_range;
    beat_nxt.last    = last_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r <= '0;
    end else begin
      beat_r <= beat_nxt;
    end
  end

  assign idx_beat = beat_r;

endmodule

### sv/cxyz_rom_fetch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cxyz_rom_fetch
// reads the two neighboring table rows around the wavelength
// ----------------------------------------------------------------------------
module cxyz_rom_fetch import cxyz_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  idx_beat_t idx_beat,
  output row_beat_t row_beat
);

  logic [ROM_AW-1:0] idx_hi;
  row_beat_t         beat_r, beat_nxt;

  always_comb begin
    idx_hi           = idx_beat.idx + ROM_AW'(1);
    beat_nxt.valid   = idx_beat.valid;
    beat_nxt.lo      = cmf_row(idx_beat.idx);
    beat_nxt.hi      = cmf_row(idx_hi);
    beat_nxt.frac    = idx_beat.frac;
    beat_nxt.covered = idx_beat.covered;
    beat_nxt.last    = idx_beat.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r <= '0;
    end else begin
      beat_r <= beat_nxt;
    end
  end

  assign row_beat = beat_r;

endmodule

### sv/cxyz_lerp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cxyz_lerp
// weighted sum of the two rows, then truncating divide by the 80-unit step
// ----------------------------------------------------------------------------
module cxyz_lerp import cxyz_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  row_beat_t row_beat,
  output logic      out_valid,
  output xyz_t      weights,
  output logic      covered,
  output logic      last_out
);

  localparam int SH_W   = SUM_W - 4;
  localparam int RCP_SH = 20;
  localparam int RCP5   = 209716;
  localparam int MUL_W  = SH_W + RCP_SH;

  logic [R_W-1:0]               frac_c;
  logic [NCH-1:0][SUM_W-1:0]    sum_nxt;
  logic [NCH-1:0][SUM_W-1:0]    sum_r;
  logic                         valid_s_r;
  logic                         cov_s_r;
  logic                         last_s_r;
  logic [NCH-1:0][MUL_W-1:0]    prod;
  xyz_t                         w_nxt;
  xyz_t                         w_r;
  logic                         valid_o_r;
  logic                         cov_o_r;
  logic                         last_o_r;

  always_comb begin
    frac_c = R_W'(STEP_Q4) - row_beat.frac;
    for (int c = 0; c < NCH; c++) begin
      sum_nxt[c] = SUM_W'(row_beat.lo[c]) * SUM_W'(frac_c)
                 + SUM_W'(row_beat.hi[c]) * SUM_W'(row_beat.frac);
    end
  end

  // divide by 16 by shift, by 5 through the reciprocal (exact below 2^18)
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      prod[c]  = MUL_W'(sum_r[c][SUM_W-1:4]) * MUL_W'(RCP5);
      w_nxt[c] = cov_s_r ? prod[c][RCP_SH +: W_W] : '0;
    end
  end

  always_ff @(posedge clk) begin
    sum_r     <= sum_nxt;
    cov_s_r   <= row_beat.covered;
    last_s_r  <= row_beat.last;
    w_r       <= w_nxt;
    cov_o_r   <= cov_s_r;
    last_o_r  <= last_s_r;
    if (!rst_n) begin
      valid_s_r <= 1'b0;
      valid_o_r <= 1'b0;
    end else begin
      valid_s_r <= row_beat.valid;
      valid_o_r <= valid_s_r;
    end
  end

  assign out_valid = valid_o_r;
  assign weights   = w_r;
  assign covered   = cov_o_r;
  assign last_out  = last_o_r;

endmodule

### sv/cie_xyz_color_match_interp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cie_xyz_color_match_interp
// cie 1931 2-degree x/y/z matching weights, linear interpolation over 5 nm rows
//
//   channel  handshake         payload
//   input    start / busy      in_wavelength_nm, in_last_in
//   result   out_valid strobe  out_x/y/z_weight, out_covered, out_last_out
//
// one beat per cycle; stages are range/index, rom read, weighted sum,
// reciprocal divide. busy stays low: nothing stalls and the receiver takes
// each strobe as it comes. synchronous reset empties the pipeline.
// ----------------------------------------------------------------------------
module cie_xyz_color_match_interp import cxyz_pkg::*; #(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  logic [WL_W-1:0] in_wavelength_nm,
  input  logic            in_last_in,
  output logic            out_valid,
  output logic [W_W-1:0]  out_x_weight,
  output logic [W_W-1:0]  out_y_weight,
  output logic [W_W-1:0]  out_z_weight,
  output logic            out_covered,
  output logic            out_last_out
);

  idx_beat_t idx_beat;
  row_beat_t row_beat;
  xyz_t      weights;

  assign busy = 1'b0;

  cxyz_index #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_index (
    .clk          (clk),
    .rst_n        (rst_n),
    .beat_in      (start & ~busy),
    .wavelength_nm(in_wavelength_nm),
    .last_in      (in_last_in),
    .idx_beat     (idx_beat)
  );

  cxyz_rom_fetch u_rom_fetch (
    .clk     (clk),
    .rst_n   (rst_n),
    .idx_beat(idx_beat),
    .row_beat(row_beat)
  );

  cxyz_lerp u_lerp (
    .clk      (clk),
    .rst_n    (rst_n),
    .row_beat (row_beat),
    .out_valid(out_valid),
    .weights  (weights),
    .covered  (out_covered),
    .last_out (out_last_out)
  );

  assign out_x_weight = weights[0];
  assign out_y_weight = weights[1];
  assign out_z_weight = weights[2];

endmodule

### tb/cie_xyz_color_match_interp_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cie_xyz_color_match_interp_tb
// self-checking bench for the cie 1931 x/y/z matching weight interpolator
//
// a table of directed wavelengths runs first: range edges, exact grid rows,
// the peak rows and out-of-range codes. Random wavelengths follow, mostly
// inside the 380..780 nm span, with some near the edges, on grid rows and
// across the full 16-bit code space. Every result beat is compared field by
// field, typed directed rows with grid weights and all others with a local
// interpolator that keeps its own matching table. The sender idles at three different rates.
// ----------------------------------------------------------------------------
module cie_xyz_color_match_interp_tb import cxyz_pkg::*; ();

  localparam int          N_POINTS    = 81;
  localparam int unsigned WL_BASE     = 6080;  // 380 nm in 1/16 nm
  localparam int unsigned WL_STEP     = 80;    // 5 nm in 1/16 nm
  localparam int unsigned WL_END      = WL_BASE + WL_STEP * (N_POINTS - 1);
  localparam int          N_RANDOM    = 1430;
  localparam int          WATCHDOG    = 1000;
  localparam int          DRAIN_WAIT  = 10;
  localparam int          N_DIRECTED  = 20;

  typedef struct packed {
    logic [W_W-1:0] x;
    logic [W_W-1:0] y;
    logic [W_W-1:0] z;
    logic           covered;
    logic           last;
  } cmf_result_t;

  typedef struct packed {
    logic [WL_W-1:0] wl;
    logic            last;
    logic            typed;
    logic [W_W-1:0]  x;
    logic [W_W-1:0]  y;
    logic [W_W-1:0]  z;
    logic            covered;
  } wl_row_t;

  logic            clk;
  logic            rst_n;
  logic            start;
  logic            busy;
  logic [WL_W-1:0] in_wavelength_nm;
  logic            in_last_in;
  logic            out_valid;
  logic [W_W-1:0]  out_x_weight;
  logic [W_W-1:0]  out_y_weight;
  logic [W_W-1:0]  out_z_weight;
  logic            out_covered;
  logic            out_last_out;

  cie_xyz_color_match_interp DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_wavelength_nm (in_wavelength_nm),
    .in_last_in       (in_last_in),
    .out_valid        (out_valid),
    .out_x_weight     (out_x_weight),
    .out_y_weight     (out_y_weight),
    .out_z_weight     (out_z_weight),
    .out_covered      (out_covered),
    .out_last_out     (out_last_out)
  );

  // cie 1931 2-degree points, q1.14, 5 nm apart from 380 nm
  int unsigned cmf_x [0:N_POINTS-1] = '{
    23, 36, 69, 125, 234, 380, 713, 1271, 2202, 3519,
    4651, 5382, 5707, 5703, 5508, 5222, 4764, 4114, 3201, 2328,
    1566, 950, 524, 241, 80, 39, 152, 477, 1037, 1796,
    2712, 3698, 4758, 5893, 7101, 8390, 9740, 11115, 12486, 13804,
    15013, 16033, 16815, 17313, 17403, 17131, 16427, 15375, 13998, 12311,
    10525, 8878, 7338, 5911, 4645, 3583, 2702, 1986, 1432, 1042,
    767, 539, 372, 259, 187, 133, 95, 67, 48, 33,
    23, 16, 11, 8, 5, 3, 3, 2, 2, 2,
    0
  };
  int unsigned cmf_y [0:N_POINTS-1] = '{
    0, 2, 2, 3, 7, 10, 20, 36, 66, 120,
    190, 275, 377, 488, 623, 786, 983, 1211, 1491, 1845,
    2277, 2774, 3408, 4237, 5292, 6673, 8241, 9965, 11633, 12996,
    14123, 14990, 15630, 16061, 16302, 16384, 16302, 16033, 15598, 14998,
    14254, 13374, 12403, 11385, 10338, 9286, 8241, 7229, 6242, 5259,
    4342, 3555, 2867, 2264, 1753, 1337, 999, 731, 524, 380,
    279, 195, 134, 93, 67, 48, 34, 25, 16, 11,
    8, 7, 3, 3, 2, 2, 2, 0, 0, 0,
    0
  };
  int unsigned cmf_z [0:N_POINTS-1] = '{
    106, 172, 329, 593, 1112, 1806, 3398, 6083, 10578, 17025,
    22702, 26591, 28624, 29206, 29034, 28575, 27348, 25036, 21096, 17070,
    13320, 10096, 7622, 5788, 4456, 3478, 2592, 1830, 1281, 939,
    691, 488, 333, 220, 143, 93, 64, 44, 34, 29,
    28, 23, 18, 16, 13, 10, 5, 3, 3, 2,
    0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
    0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
    0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
    0
  };

  // typed rows carry weights read straight off the grid; the rest use the model
  wl_row_t dir_rows [N_DIRECTED] = '{
    '{16'd0,     1'b0, 1'b1, 15'd0,     15'd0,     15'd0,   1'b0},
    '{16'hFFFF,  1'b1, 1'b1, 15'd0,     15'd0,     15'd0,   1'b0},
    '{16'd6079,  1'b0, 1'b1, 15'd0,     15'd0,     15'd0,   1'b0},
    '{16'd6080,  1'b0, 1'b1, 15'd23,    15'd0,     15'd106, 1'b1},
    '{16'd6081,  1'b1, 1'b0, 15'd0,     15'd0,     15'd0,   1'b0},
    '{16'd6159,  1'b0, 1'b0, 15'd0,     15'd0,     15'd0,   1'b0},
    '{16'd6160,  1'b0, 1'b1, 15'd36,    15'd2,     15'd172, 1'b1},
    '{16'd7000,  1'b0, 1'b0, 15'd0,     15'd0,     15'd0,   1'b0},
    '{16'd8880,  1'b1, 1'b1, 15'd8390,  15'd16384, 15'd93,  1'b1},
    '{16'd8920,  1'b0, 1'b0, 15'd0,     15'd0,     15'd0,   1'b0},
    '{16'd9600,  1'b0, 1'b1, 15'd17403, 15'd10338, 15'd13,  1'b1},
    '{16'd10000, 1'b1, 1'b1, 15'd12311, 15'd5259,  15'd2,   1'b1},
    '{16'd11000, 1'b0, 1'b0, 15'd0,     15'd0,     15'd0,   1'b0},
    '{16'd12400, 1'b0, 1'b1, 15'd2,     15'd0,     15'd0,   1'b1},
    '{16'd12479, 1'b1, 1'b0, 15'd0,     15'd0,     15'd0,   1'b0},
    '{16'd12480, 1'b0, 1'b1, 15'd0,     15'd0,     15'd0,   1'b0},
    '{16'd12481, 1'b1, 1'b1, 15'd0,     15'd0,     15'd0,   1'b0},
    '{16'h7FFF,  1'b0, 1'b1, 15'd0,     15'd0,     15'd0,   1'b0},
    '{16'h8000,  1'b1, 1'b1, 15'd0,     15'd0,     15'd0,   1'b0},
    '{16'hFFF0,  1'b0, 1'b1, 15'd0,     15'd0,     15'd0,   1'b0}
  };

  cmf_result_t weight_q [$];
  cmf_result_t next_weights;
  cmf_result_t got_weights;
  cmf_result_t want_weights;
  int          idle_pct;
  int          idle_cycles;
  int          n_errors;
  int          n_results;
  int          n_inside;
  int          n_last;

  function automatic cmf_result_t cmf_interpolate(input logic [WL_W-1:0] wl,
                                                  input logic last);
    cmf_result_t res;
    int unsigned d;
    int unsigned i;
    int unsigned r;
    res = '0;
    res.last = last;
    if (wl >= WL_BASE && wl < WL_END) begin
      d = wl - WL_BASE;
      i = d / WL_STEP;
      r = d % WL_STEP;
      res.x = W_W'((cmf_x[i] * (WL_STEP - r) + cmf_x[i+1] * r) / WL_STEP);
      res.y = W_W'((cmf_y[i] * (WL_STEP - r) + cmf_y[i+1] * r) / WL_STEP);
      res.z = W_W'((cmf_z[i] * (WL_STEP - r) + cmf_z[i+1] * r) / WL_STEP);
      res.covered = 1'b1;
    end
    return res;
  endfunction

  function automatic logic [WL_W-1:0] pick_wavelength();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 6) begin
      return WL_W'($urandom_range(WL_END - 1, WL_BASE));
    end else if (sel == 6) begin
      // straddle either end of the table
      if ($urandom_range(1))
        return WL_W'($urandom_range(WL_BASE + 12, WL_BASE - 12));
      else
        return WL_W'($urandom_range(WL_END + 12, WL_END - 12));
    end else if (sel == 7) begin
      return WL_W'(WL_BASE + WL_STEP * $urandom_range(N_POINTS - 1));
    end else begin
      return WL_W'($urandom_range(16'hFFFF));
    end
  endfunction

  task automatic send_wavelength(input logic [WL_W-1:0] wl, input logic last,
                                 input cmf_result_t want);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start            <= 1'b1;
    in_wavelength_nm <= wl;
    in_last_in       <= last;
    next_weights     = want;
    do @(posedge clk); while (busy);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // input beats enter the queue and result beats are checked at the rising edge
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      weight_q.push_back(next_weights);
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (rst_n && out_valid) begin
      idle_cycles = 0;
      got_weights = '{out_x_weight, out_y_weight, out_z_weight, out_covered,
                      out_last_out};
      if (weight_q.size() == 0) begin
        $error("result beat with no weights pending");
        n_errors++;
      end else begin
        want_weights = weight_q.pop_front();
        check_field("x_weight", want_weights.x, got_weights.x);
        check_field("y_weight", want_weights.y, got_weights.y);
        check_field("z_weight", want_weights.z, got_weights.z);
        check_field("covered", want_weights.covered, got_weights.covered);
        check_field("last_out", want_weights.last, got_weights.last);
      end
      n_results++;
      if (out_covered) n_inside++;
      if (out_last_out) n_last++;
    end
    if (idle_cycles >= WATCHDOG) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    cmf_result_t     want;
    logic [WL_W-1:0] wl;
    logic            last;
    rst_n            = 1'b0;
    start            = 1'b0;
    in_wavelength_nm = '0;
    in_last_in       = 1'b0;
    next_weights     = '0;
    idle_pct         = 33;
    idle_cycles      = 0;
    n_errors         = 0;
    n_results        = 0;
    n_inside         = 0;
    n_last           = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[k]) begin
      if (dir_rows[k].typed)
        want = '{dir_rows[k].x, dir_rows[k].y, dir_rows[k].z, dir_rows[k].covered,
                 dir_rows[k].last};
      else
        want = cmf_interpolate(dir_rows[k].wl, dir_rows[k].last);
      send_wavelength(dir_rows[k].wl, dir_rows[k].last, want);
    end

    // sender idles in a third of the cycles, then in three quarters, then never
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 3) idle_pct = 75;
      if (n == 2 * N_RANDOM / 3) idle_pct = 0;
      wl   = pick_wavelength();
      last = ($urandom_range(7) == 0);
      send_wavelength(wl, last, cmf_interpolate(wl, last));
    end
    @(negedge clk);
    start <= 1'b0;

    while (weight_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("checked %0d weight beats: %0d inside the 380-780 nm span, %0d outside",
             n_results, n_inside, n_results - n_inside);
    $display("%0d beats carried the last marker, %0d mismatches", n_last, n_errors);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
